### hdl/vrp_pkg.sv
package vrp_pkg;

    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int COORD_W     = 16;
    localparam int PIX_W       = 12;
    localparam int DEPTH_W     = 16;

    localparam int PROD_W      = 32;
    localparam int ROT1_W      = 33;
    localparam int ROT2_W      = 48;
    localparam int DEN_W       = 49;
    localparam int NUM_W       = 57;
    localparam int MAG_W       = 56;
    localparam int DENM_W      = 48;
    localparam int QB          = 13;
    localparam int REM_W       = DENM_W + QB;
    localparam int PIX_SUM_W   = 15;
    localparam int PITCH_SHIFT = 14;
    localparam int NUMX_SHIFT  = 14;
    localparam int DEPTH_SHIFT = 28;
    localparam int DTR_W       = ROT2_W - DEPTH_SHIFT;

    localparam logic [CFG_IDX_W-1:0] REG_COS_YAW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_YAW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_PITCH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_PITCH = 2'd3;

    localparam logic signed [CFG_W-1:0] TRIG_ONE  = 16'sd16384;
    localparam logic signed [CFG_W-1:0] TRIG_ZERO = 16'sd0;

    localparam logic signed [NUM_W-1:0] PROJ_GAIN  = 57'sd440;
    localparam logic signed [DEN_W-1:0] DEN_OFFSET = DEN_W'(64'sd5 <<< 40);

    localparam logic signed [PIX_SUM_W-1:0] PIX_MAX = 15'sd2047;
    localparam logic signed [PIX_SUM_W-1:0] PIX_MIN = -15'sd2048;
    localparam logic signed [DTR_W-1:0]     DEP_MAX = 20'sd32767;
    localparam logic signed [DTR_W-1:0]     DEP_MIN = -20'sd32768;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
    } vertex_t;

    typedef struct packed {
        logic signed [PIX_W-1:0]   screen_x;
        logic signed [PIX_W-1:0]   screen_y;
        logic signed [DEPTH_W-1:0] rotated_depth;
        logic                      behind_camera;
        logic                      coord_saturated;
    } result_t;

endpackage

### hdl/vertex_rotate_project.sv
// Channel   Direction  Signals                                  Transfer when
// vertex    in         vertex_valid, vertex_ready, vertex       valid and ready high
// result    out        result_valid, result_ready, result       valid and ready high
// config    in         cfg_wen, cfg_index, cfg_wdata            cfg_wen high
//
// One vertex enters per cycle while vertex_ready is high.
// Two rotation multiply stages feed 13 restoring divide stages that produce
// the screen quotients in parallel for x and y.
// Reset clears all valid bits and loads the identity rotation.
// A stalled result is held in the output register, one more in a skid register;
// when the skid register is full the whole pipeline holds and vertex_ready is low.
module vertex_rotate_project
    import vrp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 vertex_valid,
    output logic                 vertex_ready,
    input  vertex_t              vertex,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result
);

    localparam logic signed [PIX_SUM_W-1:0] CENTER_X = PIX_SUM_W'(SCREEN_WIDTH / 2);
    localparam logic signed [PIX_SUM_W-1:0] CENTER_Y = PIX_SUM_W'(SCREEN_HEIGHT / 2);

    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        logic                      depth_sat;
        logic                      behind;
        logic                      neg_x;
        logic                      neg_y;
        logic                      ovf_x;
        logic                      ovf_y;
    } side_t;

    logic signed [CFG_W-1:0] cos_yaw_reg;
    logic signed [CFG_W-1:0] sin_yaw_reg;
    logic signed [CFG_W-1:0] cos_pitch_reg;
    logic signed [CFG_W-1:0] sin_pitch_reg;

    logic en;

    logic v_s1_reg, v_s2_reg, v_s3_reg, v_s4_reg, v_s5_reg, v_s6_reg;

    logic signed [PROD_W-1:0]  s1_xcy_reg, s1_zsy_reg, s1_xsy_reg, s1_zcy_reg;
    logic signed [COORD_W-1:0] s1_y_reg;

    logic signed [ROT1_W-1:0]  s2_x1_reg, s2_z1_reg;
    logic signed [COORD_W-1:0] s2_y_reg;

    logic signed [PROD_W-1:0]  s3_ycp_reg, s3_ysp_reg;
    logic signed [ROT2_W-1:0]  s3_z1sp_reg, s3_z1cp_reg;
    logic signed [ROT1_W-1:0]  s3_x1_reg;

    logic signed [ROT2_W-1:0]  s4_y1_reg, s4_z2_reg;
    logic signed [ROT1_W-1:0]  s4_x1_reg;

    logic signed [NUM_W-1:0]   s5_numx_reg, s5_numy_reg;
    logic signed [DEN_W-1:0]   s5_den_reg;
    logic signed [DTR_W-1:0]   s5_dtr_reg;

    logic [MAG_W-1:0]          s6_magx_reg, s6_magy_reg;
    logic [DENM_W-1:0]         s6_den_reg;
    side_t                     s6_side_reg;

    logic [MAG_W-1:0]          s6_magx_next, s6_magy_next;
    side_t                     s6_side_next;
    logic signed [NUM_W-1:0]   negx_full, negy_full;

    logic                      dv_v_reg    [0:QB];
    logic [REM_W-1:0]          dv_remx_reg [0:QB];
    logic [REM_W-1:0]          dv_remy_reg [0:QB];
    logic [QB-1:0]             dv_qx_reg   [0:QB];
    logic [QB-1:0]             dv_qy_reg   [0:QB];
    logic [DENM_W-1:0]         dv_den_reg  [0:QB];
    side_t                     dv_side_reg [0:QB];

    logic [REM_W-1:0]          dv_remx_next [1:QB];
    logic [REM_W-1:0]          dv_remy_next [1:QB];
    logic [QB-1:0]             dv_qx_next   [1:QB];
    logic [QB-1:0]             dv_qy_next   [1:QB];
    side_t                     dv_side_next0;

    logic                      fin_v_reg;
    result_t                   fin_reg;
    result_t                   fin_next;

    logic                      out_v_reg, skid_v_reg;
    result_t                   out_reg, skid_reg;

    assign en           = !skid_v_reg;
    assign vertex_ready = en;
    assign result_valid = out_v_reg;
    assign result       = out_reg;

    // Stage 6: magnitudes of the numerators, camera-plane test, depth clamp.
    always_comb
    begin
        negx_full = -s5_numx_reg;
        negy_full = -s5_numy_reg;
        s6_magx_next = s5_numx_reg[NUM_W-1] ? negx_full[MAG_W-1:0] : s5_numx_reg[MAG_W-1:0];
        s6_magy_next = s5_numy_reg[NUM_W-1] ? negy_full[MAG_W-1:0] : s5_numy_reg[MAG_W-1:0];
        s6_side_next.neg_x  = s5_numx_reg[NUM_W-1];
        s6_side_next.neg_y  = s5_numy_reg[NUM_W-1];
        s6_side_next.behind = s5_den_reg[DEN_W-1] || (s5_den_reg == '0);
        s6_side_next.ovf_x  = 1'b0;
        s6_side_next.ovf_y  = 1'b0;
        if (s5_dtr_reg > DEP_MAX)
        begin
            s6_side_next.depth     = DEP_MAX[DEPTH_W-1:0];
            s6_side_next.depth_sat = 1'b1;
        end
        else if (s5_dtr_reg < DEP_MIN)
        begin
            s6_side_next.depth     = DEP_MIN[DEPTH_W-1:0];
            s6_side_next.depth_sat = 1'b1;
        end
        else
        begin
            s6_side_next.depth     = s5_dtr_reg[DEPTH_W-1:0];
            s6_side_next.depth_sat = 1'b0;
        end
    end

    // Divider entry: a quotient of 2^13 or more saturates the screen value anyway.
    always_comb
    begin
        dv_side_next0       = s6_side_reg;
        dv_side_next0.ovf_x = REM_W'(s6_magx_reg) >= (REM_W'(s6_den_reg) << QB);
        dv_side_next0.ovf_y = REM_W'(s6_magy_reg) >= (REM_W'(s6_den_reg) << QB);
    end

    // One restoring quotient bit per stage, most significant bit first.
    always_comb
    begin
        logic [REM_W-1:0] sub;
        logic             fit_x, fit_y;
        for (int i = 0; i < QB; i++)
        begin
            sub   = REM_W'(dv_den_reg[i]) << (QB - 1 - i);
            fit_x = dv_remx_reg[i] >= sub;
            fit_y = dv_remy_reg[i] >= sub;
            dv_remx_next[i+1] = fit_x ? dv_remx_reg[i] - sub : dv_remx_reg[i];
            dv_remy_next[i+1] = fit_y ? dv_remy_reg[i] - sub : dv_remy_reg[i];
            dv_qx_next[i+1]   = dv_qx_reg[i] | (QB'(fit_x) << (QB - 1 - i));
            dv_qy_next[i+1]   = dv_qy_reg[i] | (QB'(fit_y) << (QB - 1 - i));
        end
    end

    // Final stage: sign, screen center, clamp to the pixel range; zero position behind the camera.
    always_comb
    begin
        logic [QB-1:0]                qx, qy;
        logic signed [PIX_SUM_W-1:0]  off_x, off_y, sum_x, sum_y;
        logic                         sat_x, sat_y;
        side_t                        sd;
        sd    = dv_side_reg[QB];
        qx    = sd.ovf_x ? '1 : dv_qx_reg[QB];
        qy    = sd.ovf_y ? '1 : dv_qy_reg[QB];
        off_x = sd.neg_x ? -PIX_SUM_W'(qx) : PIX_SUM_W'(qx);
        off_y = sd.neg_y ? -PIX_SUM_W'(qy) : PIX_SUM_W'(qy);
        sum_x = CENTER_X + off_x;
        sum_y = CENTER_Y + off_y;
        sat_x = 1'b0;
        sat_y = 1'b0;
        if (sd.behind)
        begin
            fin_next.screen_x = '0;
        end
        else if (sum_x > PIX_MAX)
        begin
            fin_next.screen_x = PIX_MAX[PIX_W-1:0];
            sat_x = 1'b1;
        end
        else if (sum_x < PIX_MIN)
        begin
            fin_next.screen_x = PIX_MIN[PIX_W-1:0];
            sat_x = 1'b1;
        end
        else
        begin
            fin_next.screen_x = sum_x[PIX_W-1:0];
        end
        if (sd.behind)
        begin
            fin_next.screen_y = '0;
        end
        else if (sum_y > PIX_MAX)
        begin
            fin_next.screen_y = PIX_MAX[PIX_W-1:0];
            sat_y = 1'b1;
        end
        else if (sum_y < PIX_MIN)
        begin
            fin_next.screen_y = PIX_MIN[PIX_W-1:0];
            sat_y = 1'b1;
        end
        else
        begin
            fin_next.screen_y = sum_y[PIX_W-1:0];
        end
        fin_next.rotated_depth   = sd.depth;
        fin_next.behind_camera   = sd.behind;
        fin_next.coord_saturated = sd.depth_sat || sat_x || sat_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_yaw_reg   <= TRIG_ONE;
            sin_yaw_reg   <= TRIG_ZERO;
            cos_pitch_reg <= TRIG_ONE;
            sin_pitch_reg <= TRIG_ZERO;
            v_s1_reg      <= 1'b0;
            v_s2_reg      <= 1'b0;
            v_s3_reg      <= 1'b0;
            v_s4_reg      <= 1'b0;
            v_s5_reg      <= 1'b0;
            v_s6_reg      <= 1'b0;
            for (int i = 0; i <= QB; i++)
            begin
                dv_v_reg[i] <= 1'b0;
            end
            fin_v_reg     <= 1'b0;
            out_v_reg     <= 1'b0;
            skid_v_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    REG_COS_YAW:   cos_yaw_reg   <= cfg_wdata;
                    REG_SIN_YAW:   sin_yaw_reg   <= cfg_wdata;
                    REG_COS_PITCH: cos_pitch_reg <= cfg_wdata;
                    REG_SIN_PITCH: sin_pitch_reg <= cfg_wdata;
                    default:       ;
                endcase
            end
            if (en)
            begin
                v_s1_reg    <= vertex_valid;
                v_s2_reg    <= v_s1_reg;
                v_s3_reg    <= v_s2_reg;
                v_s4_reg    <= v_s3_reg;
                v_s5_reg    <= v_s4_reg;
                v_s6_reg    <= v_s5_reg;
                dv_v_reg[0] <= v_s6_reg;
                for (int i = 0; i < QB; i++)
                begin
                    dv_v_reg[i+1] <= dv_v_reg[i];
                end
                fin_v_reg   <= dv_v_reg[QB];
            end
            if (skid_v_reg)
            begin
                if (!out_v_reg || result_ready)
                begin
                    out_v_reg  <= 1'b1;
                    skid_v_reg <= 1'b0;
                end
            end
            else if (!out_v_reg || result_ready)
            begin
                out_v_reg <= fin_v_reg;
            end
            else if (fin_v_reg)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_xcy_reg <= vertex.vertex_x * cos_yaw_reg;
            s1_zsy_reg <= vertex.vertex_z * sin_yaw_reg;
            s1_xsy_reg <= vertex.vertex_x * sin_yaw_reg;
            s1_zcy_reg <= vertex.vertex_z * cos_yaw_reg;
            s1_y_reg   <= vertex.vertex_y;

            s2_x1_reg  <= ROT1_W'(s1_xcy_reg) - ROT1_W'(s1_zsy_reg);
            s2_z1_reg  <= ROT1_W'(s1_xsy_reg) + ROT1_W'(s1_zcy_reg);
            s2_y_reg   <= s1_y_reg;

            s3_ycp_reg  <= s2_y_reg * cos_pitch_reg;
            s3_ysp_reg  <= s2_y_reg * sin_pitch_reg;
            s3_z1sp_reg <= ROT2_W'(s2_z1_reg) * ROT2_W'(sin_pitch_reg);
            s3_z1cp_reg <= ROT2_W'(s2_z1_reg) * ROT2_W'(cos_pitch_reg);
            s3_x1_reg   <= s2_x1_reg;

            s4_y1_reg <= (ROT2_W'(s3_ycp_reg) <<< PITCH_SHIFT) - s3_z1sp_reg;
            s4_z2_reg <= (ROT2_W'(s3_ysp_reg) <<< PITCH_SHIFT) + s3_z1cp_reg;
            s4_x1_reg <= s3_x1_reg;

            s5_numx_reg <= (NUM_W'(s4_x1_reg) * PROJ_GAIN) <<< NUMX_SHIFT;
            s5_numy_reg <= NUM_W'(s4_y1_reg) * PROJ_GAIN;
            s5_den_reg  <= DEN_W'(s4_z2_reg) + DEN_OFFSET;
            s5_dtr_reg  <= s4_z2_reg[ROT2_W-1:DEPTH_SHIFT]
                         + DTR_W'(s4_z2_reg[ROT2_W-1] && (s4_z2_reg[DEPTH_SHIFT-1:0] != '0));

            s6_magx_reg <= s6_magx_next;
            s6_magy_reg <= s6_magy_next;
            s6_den_reg  <= s5_den_reg[DENM_W-1:0];
            s6_side_reg <= s6_side_next;

            dv_remx_reg[0] <= REM_W'(s6_magx_reg);
            dv_remy_reg[0] <= REM_W'(s6_magy_reg);
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
            dv_den_reg[0]  <= s6_den_reg;
            dv_side_reg[0] <= dv_side_next0;
            for (int i = 0; i < QB; i++)
            begin
                dv_remx_reg[i+1] <= dv_remx_next[i+1];
                dv_remy_reg[i+1] <= dv_remy_next[i+1];
                dv_qx_reg[i+1]   <= dv_qx_next[i+1];
                dv_qy_reg[i+1]   <= dv_qy_next[i+1];
                dv_den_reg[i+1]  <= dv_den_reg[i];
                dv_side_reg[i+1] <= dv_side_reg[i];
            end

            fin_reg <= fin_next;
        end
        if (skid_v_reg)
        begin
            if (!out_v_reg || result_ready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_v_reg || result_ready)
        begin
            out_reg <= fin_reg;
        end
        else
        begin
            skid_reg <= fin_reg;
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("Skid register holds a result while the output register is empty.");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(result_valid && !result_ready))
        else $error("Skid register filled without a stalled result transfer.");

    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.behind_camera) |->
            (result.screen_x == '0 && result.screen_y == '0))
        else $error("A vertex behind the camera has a nonzero screen position.");

endmodule

### tb/sv/vertex_rotate_project_tb.sv
`timescale 1ns / 100ps

module vertex_rotate_project_tb;
    import vrp_pkg::*;

    localparam int SCREEN_W = 640;
    localparam int SCREEN_H = 480;
    localparam int LATENCY = 22;
    localparam longint PIX_LO = -2048;
    localparam longint PIX_HI = 2047;
    localparam longint DEPTH_LO = -32768;
    localparam longint DEPTH_HI = 32767;
    localparam logic [CFG_IDX_W-1:0] ROT_REGS [4] =
        '{REG_COS_YAW, REG_SIN_YAW, REG_COS_PITCH, REG_SIN_PITCH};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_COS_YAW;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic vertex_valid = 1'b0;
    logic vertex_ready;
    vertex_t vertex = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;

    logic signed [CFG_W-1:0] trig [4] = '{TRIG_ONE, TRIG_ZERO, TRIG_ONE, TRIG_ZERO};
    result_t expected_projections [$];
    bit src_gaps = 1'b1;
    bit sink_stalls = 1'b1;
    int mismatch_count = 0;

    vertex_rotate_project #(
        .SCREEN_WIDTH(SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wen(cfg_wen),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .vertex_valid(vertex_valid),
        .vertex_ready(vertex_ready),
        .vertex(vertex),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint saturate(input longint v, input longint lo, input longint hi,
                                        inout bit clipped);
        if (v < lo)
        begin
            clipped = 1'b1;
            return lo;
        end
        if (v > hi)
        begin
            clipped = 1'b1;
            return hi;
        end
        return v;
    endfunction

    function automatic result_t project_vertex(input vertex_t v);
        longint x, y, z, cy, sy, cp, sp;
        longint x1, z1, y1, z2, den, depth, qx, qy, sx, syv;
        bit clipped;
        bit behind;
        result_t r;
        x = $signed(v.vertex_x);
        y = $signed(v.vertex_y);
        z = $signed(v.vertex_z);
        cy = trig[REG_COS_YAW];
        sy = trig[REG_SIN_YAW];
        cp = trig[REG_COS_PITCH];
        sp = trig[REG_SIN_PITCH];
        clipped = 1'b0;
        sx = 0;
        syv = 0;
        // The first rotation is scaled by 2^14, the second by 2^28.
        x1 = x * cy - z * sy;
        z1 = x * sy + z * cy;
        y1 = y * cp * 16384 - z1 * sp;
        z2 = y * sp * 16384 + z1 * cp;
        depth = saturate(z2 / (64'sd1 <<< DEPTH_SHIFT), DEPTH_LO, DEPTH_HI, clipped);
        den = z2 + (64'sd5 <<< 40);
        behind = (den <= 0);
        if (!behind)
        begin
            qx = (x1 * 440 * 16384) / den;
            qy = (y1 * 440) / den;
            sx = saturate(SCREEN_W / 2 + qx, PIX_LO, PIX_HI, clipped);
            syv = saturate(SCREEN_H / 2 + qy, PIX_LO, PIX_HI, clipped);
        end
        r.screen_x = sx[PIX_W-1:0];
        r.screen_y = syv[PIX_W-1:0];
        r.rotated_depth = depth[DEPTH_W-1:0];
        r.behind_camera = behind;
        r.coord_saturated = clipped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= !sink_stalls || ($urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_projections.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: x=%0d y=%0d depth=%0d behind=%0b sat=%0b",
                             result.screen_x, result.screen_y, result.rotated_depth,
                             result.behind_camera, result.coord_saturated);
            end
            else
            begin
                want = expected_projections.pop_front();
                if (result.screen_x !== want.screen_x || result.screen_y !== want.screen_y
                    || result.rotated_depth !== want.rotated_depth
                    || result.behind_camera !== want.behind_camera
                    || result.coord_saturated !== want.coord_saturated)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("Mismatch: expected x=%0d y=%0d depth=%0d behind=%0b sat=%0b",
                                 want.screen_x, want.screen_y, want.rotated_depth,
                                 want.behind_camera, want.coord_saturated);
                        $display("          got      x=%0d y=%0d depth=%0d behind=%0b sat=%0b",
                                 result.screen_x, result.screen_y, result.rotated_depth,
                                 result.behind_camera, result.coord_saturated);
                    end
                end
            end
        end
    end

    task automatic send_vertex(input vertex_t v);
        while (src_gaps && $urandom_range(99) < 35)
        begin
            vertex_valid <= 1'b0;
            @(posedge clk);
        end
        vertex_valid <= 1'b1;
        vertex <= v;
        do
            @(posedge clk);
        while (!vertex_ready);
        expected_projections.push_back(project_vertex(v));
    endtask

    task automatic finish_burst();
        vertex_valid <= 1'b0;
        while (expected_projections.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_rotation(input logic signed [CFG_W-1:0] cy,
                                 input logic signed [CFG_W-1:0] sy,
                                 input logic signed [CFG_W-1:0] cp,
                                 input logic signed [CFG_W-1:0] sp);
        logic signed [CFG_W-1:0] vals [4];
        vals = '{cy, sy, cp, sp};
        for (int i = 0; i < 4; i++)
        begin
            cfg_wen <= 1'b1;
            cfg_index <= ROT_REGS[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
            trig[ROT_REGS[i]] = vals[i];
        end
        cfg_wen <= 1'b0;
    endtask

    function automatic vertex_t random_vertex();
        vertex_t v;
        int kind;
        kind = $urandom_range(9);
        v.vertex_x = 16'($urandom);
        v.vertex_y = 16'($urandom);
        v.vertex_z = 16'($urandom);
        if (kind < 2)
        begin
            v.vertex_x = 16'(int'($urandom_range(16383)) - 8192);
            v.vertex_y = 16'(int'($urandom_range(16383)) - 8192);
            v.vertex_z = 16'(int'($urandom_range(16383)) - 8192);
        end
        else if (kind < 4)
            v.vertex_z = 16'(int'($urandom_range(40)) - 20500);
        return v;
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_vertex(random_vertex());
    endtask

    task automatic test_directed_corners();
        vertex_t plain_corners [10];
        vertex_t turned_corners [4];
        plain_corners = '{
            '{16'sd0, 16'sd0, 16'sd0},
            '{16'sd32767, 16'sd32767, 16'sd32767},
            '{-16'sd32768, -16'sd32768, -16'sd32768},
            '{16'sd32767, -16'sd32768, 16'sd0},
            '{-16'sd32768, 16'sd32767, 16'sd0},
            '{16'sd4096, 16'sd4096, -16'sd20479},
            '{16'sd4096, -16'sd4096, -16'sd20480},
            '{16'sd0, 16'sd0, -16'sd20481},
            '{16'sd1, 16'sd1, -16'sd20479},
            '{-16'sd32768, -16'sd32768, -16'sd20470}
        };
        turned_corners = '{
            '{16'sd32767, 16'sd32767, 16'sd32767},
            '{-16'sd32768, -16'sd32768, -16'sd32768},
            '{16'sd32767, 16'sd0, -16'sd32768},
            '{16'sd0, 16'sd32767, 16'sd0}
        };
        foreach (plain_corners[i])
            send_vertex(plain_corners[i]);
        finish_burst();
        load_rotation(16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585);
        foreach (turned_corners[i])
            send_vertex(turned_corners[i]);
        finish_burst();
    endtask

    task automatic test_register_extremes();
        load_rotation(-16'sd16384, 16'sd0, -16'sd16384, 16'sd0);
        send_random(30);
        finish_burst();
        load_rotation(16'sd0, 16'sd16384, 16'sd0, 16'sd16384);
        send_random(30);
        finish_burst();
        load_rotation(16'sd0, -16'sd16384, 16'sd0, -16'sd16384);
        send_random(30);
        finish_burst();
        load_rotation(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
        send_random(30);
        finish_burst();
        load_rotation(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        send_random(30);
        finish_burst();
        load_rotation(TRIG_ONE, TRIG_ZERO, TRIG_ONE, TRIG_ZERO);
        send_random(30);
        finish_burst();
    endtask

    task automatic test_random_rotations();
        real yaw, pitch;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase % 2 == 0)
            begin
                yaw = $urandom_range(359) * 3.14159265 / 180.0;
                pitch = $urandom_range(359) * 3.14159265 / 180.0;
                load_rotation(16'($rtoi($cos(yaw) * 16384.0)),
                              16'($rtoi($sin(yaw) * 16384.0)),
                              16'($rtoi($cos(pitch) * 16384.0)),
                              16'($rtoi($sin(pitch) * 16384.0)));
            end
            else
                load_rotation(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            send_random(80);
            finish_burst();
        end
    endtask

    task automatic test_back_to_back();
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        load_rotation(16'sd14189, 16'sd8192, 16'sd15137, -16'sd6270);
        send_random(250);
        finish_burst();
        src_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    task automatic test_bursts_with_drain();
        load_rotation(TRIG_ONE, TRIG_ZERO, TRIG_ONE, TRIG_ZERO);
        for (int b = 0; b < 5; b++)
        begin
            send_random($urandom_range(50, 10));
            finish_burst();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_register_extremes();
        test_random_rotations();
        test_back_to_back();
        test_bursts_with_drain();
        finish_burst();
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
